FILE: hdl/per_source_icmp_token_bucket_macros.svh
// Assertion macros used by the token bucket module to check its own logic.
`ifndef PER_SOURCE_ICMP_TOKEN_BUCKET_MACROS_SVH
`define PER_SOURCE_ICMP_TOKEN_BUCKET_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define PSITB_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define PSITB_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/psitb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package psitb_pkg;

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;

  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_TOPUP    = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  typedef struct packed {
    logic        live;
    logic [31:0] key;
    logic        hit;
    logic [7:0]  tokens;
    logic [63:0] stamp;
    logic        free;
  } probe_t;

  typedef struct packed {
    logic        en;
    logic [31:0] key;
    logic [7:0]  tokens;
    logic [63:0] stamp;
  } wr_t;

endpackage
`default_nettype wire

FILE: hdl/per_source_icmp_token_bucket.sv
// Per-source ICMP token bucket. Packets that are not complete Ethernet IPv4
// ICMP get a pass verdict, registered from the idle state, without touching
// the table. An ICMP item walks a row of TABLE_ENTRIES cells, one cell per
// cycle; on a hit it may then run an eight-bit bit-serial division for the
// refill, and it then updates the bucket. One item is in work at a time, and
// a new item is taken once the previous verdict has been delivered.
// Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none
module per_source_icmp_token_bucket import psitb_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        has_eth_header,
  input  wire logic [15:0] ethertype,
  input  wire logic        has_ip_header,
  input  wire logic [7:0]  ip_protocol,
  input  wire logic [31:0] source_addr,
  input  wire logic [63:0] time_ns,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             drop,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [40:0] cfg_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_SUM  = 6'b010000,
    S_UPD  = 6'b100000
  } state_t;

  state_t state;

  logic [40:0] interval;
  logic [7:0]  topup;
  logic [7:0]  capacity;

  logic [31:0]      cur_key;
  logic [63:0]      cur_time;
  logic [7:0]       hit_tok;
  logic [63:0]      hit_stamp;
  logic [IDX_W-1:0] hit_idx;
  logic [7:0]       new_tok;
  logic [63:0]      new_stamp;
  logic [7:0]       quo;
  logic [63:0]      rem;
  logic [48:0]      dsr;
  logic [2:0]       step;

  probe_t           probe    [0:TABLE_ENTRIES];
  logic [IDX_W-1:0] hidx     [0:TABLE_ENTRIES];
  logic [IDX_W-1:0] fidx     [0:TABLE_ENTRIES];
  wr_t              wr;
  logic [IDX_W-1:0] wr_idx;

  logic        in_acc;
  logic        is_icmp;
  logic [40:0] ivl;
  logic [63:0] elapsed;
  logic        refill;
  logic        big;
  logic [63:0] dsr_wide;
  logic [15:0] prod;
  logic [16:0] sum;
  probe_t      res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign in_acc    = in_valid && !in_stall;
  assign is_icmp   = has_eth_header && ethertype == ETH_IPV4 && has_ip_header &&
                     ip_protocol == PROTO_ICMP;
  assign ivl       = (interval == '0) ? 41'd1 : interval;
  assign elapsed   = cur_time - hit_stamp;
  assign refill    = elapsed > {23'd0, ivl};
  assign big       = {8'd0, elapsed} >= {23'd0, ivl, 8'd0};
  assign dsr_wide  = {15'd0, dsr};
  assign prod      = {8'd0, quo} * {8'd0, topup};
  assign sum       = {9'd0, hit_tok} + {1'b0, prod};
  assign res       = probe[TABLE_ENTRIES];

  always_comb begin
    probe[0]      = '0;
    probe[0].live = in_acc && is_icmp;
    probe[0].key  = source_addr;
    hidx[0]       = '0;
    fidx[0]       = '0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    psitb_cell #(.IDX_W(IDX_W), .INDEX(i)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .probe_in    (probe[i]),
      .hit_idx_in  (hidx[i]),
      .free_idx_in (fidx[i]),
      .probe_out   (probe[i+1]),
      .hit_idx_out (hidx[i+1]),
      .free_idx_out(fidx[i+1]),
      .wr          (wr),
      .wr_idx      (wr_idx)
    );
  end

  always_comb begin
    wr        = '0;
    wr.key    = cur_key;
    wr_idx    = hit_idx;
    wr.stamp  = new_stamp;
    wr.tokens = (new_tok != '0) ? new_tok - 8'd1 : 8'd0;
    if (state == S_UPD) begin
      wr.en = 1'b1;
    end else if (state == S_SCAN && res.live && !res.hit && res.free) begin
      wr.en     = 1'b1;
      wr_idx    = fidx[TABLE_ENTRIES];
      wr.stamp  = cur_time;
      wr.tokens = (capacity != '0) ? capacity - 8'd1 : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= 41'd5000000000;
      topup    <= 8'd5;
      capacity <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INTERVAL: interval <= cfg_data;
        REG_TOPUP:    topup    <= cfg_data[7:0];
        REG_CAPACITY: capacity <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            cur_key  <= source_addr;
            cur_time <= time_ns;
            if (is_icmp) begin
              state <= S_SCAN;
            end else begin
              drop      <= 1'b0;
              out_valid <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (res.live) begin
            hit_tok   <= res.tokens;
            hit_stamp <= res.stamp;
            hit_idx   <= hidx[TABLE_ENTRIES];
            if (res.hit) begin
              state <= S_CHK;
            end else begin
              drop      <= 1'b0;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end
        end
        S_CHK: begin
          new_stamp <= refill ? cur_time : hit_stamp;
          if (!refill) begin
            new_tok <= hit_tok;
            state   <= S_UPD;
          end else if (big || topup == '0) begin
            if (topup != '0) begin
              new_tok <= capacity;
            end else begin
              new_tok <= (hit_tok > capacity) ? capacity : hit_tok;
            end
            state <= S_UPD;
          end else begin
            rem   <= elapsed;
            dsr   <= {ivl, 8'd0} >> 1;
            quo   <= '0;
            step  <= 3'd7;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem >= dsr_wide) begin
            rem <= rem - dsr_wide;
            quo <= {quo[6:0], 1'b1};
          end else begin
            quo <= {quo[6:0], 1'b0};
          end
          dsr  <= dsr >> 1;
          step <= step - 3'd1;
          if (step == '0) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          new_tok <= (sum > {9'd0, capacity}) ? capacity : sum[7:0];
          state   <= S_UPD;
        end
        S_UPD: begin
          drop      <= (new_tok == '0);
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "per_source_icmp_token_bucket_macros.svh"

  `PSITB_ASSERT_NOW(a_onehot, 1'b1, $onehot(state), "state is not one-hot")
  `PSITB_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(drop), "verdict lost")
  `PSITB_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "second item taken while busy")
  `PSITB_ASSERT_NOW(a_scan, res.live, state == S_SCAN, "probe left chain outside scan")

endmodule
`default_nettype wire

FILE: hdl/psitb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module psitb_cell import psitb_pkg::*; #(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire probe_t           probe_in,
  input  wire logic [IDX_W-1:0] hit_idx_in,
  input  wire logic [IDX_W-1:0] free_idx_in,
  output probe_t                probe_out,
  output logic      [IDX_W-1:0] hit_idx_out,
  output logic      [IDX_W-1:0] free_idx_out,
  input  wire wr_t              wr,
  input  wire logic [IDX_W-1:0] wr_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic        valid;
  logic [31:0] key;
  logic [7:0]  tokens;
  logic [63:0] stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && wr_idx == MY_IDX) begin
      valid <= 1'b1;
    end
    if (wr.en && wr_idx == MY_IDX) begin
      key    <= wr.key;
      tokens <= wr.tokens;
      stamp  <= wr.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out    <= probe_in;
      hit_idx_out  <= hit_idx_in;
      free_idx_out <= free_idx_in;
      if (!probe_in.hit && valid && key == probe_in.key) begin
        probe_out.hit    <= 1'b1;
        probe_out.tokens <= tokens;
        probe_out.stamp  <= stamp;
        hit_idx_out      <= MY_IDX;
      end
      if (!probe_in.free && !valid) begin
        probe_out.free <= 1'b1;
        free_idx_out   <= MY_IDX;
      end
    end
  end

endmodule
`default_nettype wire
